/* sv/rbfalu_pkg.sv */
// shared types and constants for the integer execute unit with bit-field ops
// no dependencies; used by rbfalu_exec and risc_integer_alu_with_bitfield_core
package rbfalu_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned FieldW = 5;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_AND  = 4'd2,
        OP_ANDC = 4'd3,
        OP_OR   = 4'd4,
        OP_ORC  = 4'd5,
        OP_XOR  = 4'd6,
        OP_XORC = 4'd7,
        OP_CMP  = 4'd8,
        OP_ROT  = 4'd9,
        OP_MAK  = 4'd10,
        OP_SET  = 4'd11,
        OP_CLR  = 4'd12,
        OP_EXT  = 4'd13,
        OP_EXTU = 4'd14,
        OP_COND = 4'd15
    } op_t;

    // compare flag word pieces
    localparam logic [DataW-1:0] CMP_EQ_WORD = 32'h0000_0aa4;
    localparam logic [DataW-1:0] CMP_NE_BIT  = 32'h0000_0008;
    localparam logic [DataW-1:0] CMP_HI_BITS = 32'h0000_0900;
    localparam logic [DataW-1:0] CMP_LS_BITS = 32'h0000_0600;
    localparam logic [DataW-1:0] CMP_GT_BITS = 32'h0000_0090;
    localparam logic [DataW-1:0] CMP_LE_BITS = 32'h0000_0060;
    localparam logic [DataW-1:0] SIGN_WORD   = 32'h8000_0000;

    typedef struct packed {
        op_t               req_type;
        logic [DataW-1:0]  operand_a;
        logic [DataW-1:0]  operand_b;
        logic [FieldW-1:0] field_width;
        logic [FieldW-1:0] field_offset;
        logic              imm_form;
        logic [1:0]        carry_mode;
        logic [3:0]        cond_mask;
    } req_t;

    typedef struct packed {
        logic [DataW-1:0] result;
        logic             branch_taken;
        logic             carry_flag;
    } rsp_t;

endpackage

/* sv/rbfalu_exec.sv */
// combinational execute logic: arithmetic, logic, compare, rotate, bit-field, condition
// depends on rbfalu_pkg
module rbfalu_exec (
    input  rbfalu_pkg::req_t req,
    input  logic             carry,
    output rbfalu_pkg::rsp_t rsp
);

    logic [rbfalu_pkg::FieldW-1:0] w;
    logic [rbfalu_pkg::FieldW-1:0] off;
    logic [rbfalu_pkg::FieldW-1:0] ext_sh;
    logic [rbfalu_pkg::DataW-1:0]  a;
    logic [rbfalu_pkg::DataW-1:0]  b;
    logic [rbfalu_pkg::DataW-1:0]  wm;
    logic [rbfalu_pkg::DataW-1:0]  bb;
    logic                          is_sub;
    logic                          cin;
    logic [rbfalu_pkg::DataW:0]    sum;
    logic [2*rbfalu_pkg::DataW-1:0] rot_wide;
    logic [rbfalu_pkg::DataW-1:0]  asr_val;
    logic [rbfalu_pkg::DataW-1:0]  ext_val;
    logic [rbfalu_pkg::DataW-1:0]  cmp_word;
    logic                          neg;
    logic                          is_zero;
    logic                          is_min;
    logic                          taken;

    assign a   = req.operand_a;
    assign b   = req.operand_b;
    assign w   = req.imm_form ? req.field_width  : b[9:5];
    assign off = req.imm_form ? req.field_offset : b[4:0];

    // width 0 selects the whole word
    assign wm = (w == '0) ? '1 : ~({rbfalu_pkg::DataW{1'b1}} << w);

    assign is_sub = (req.req_type == rbfalu_pkg::OP_SUB);
    assign bb     = is_sub ? ~b : b;
    assign cin    = req.carry_mode[0] ? carry : is_sub;
    assign sum    = {1'b0, a} + {1'b0, bb} + {{rbfalu_pkg::DataW{1'b0}}, cin};

    assign rot_wide = {a, a} >> off;

    // signed extract: shift the field to the top, then back down arithmetically
    assign asr_val = $signed(a) >>> off;
    assign ext_sh  = 5'd0 - w;
    assign ext_val = $signed(asr_val << ext_sh) >>> ext_sh;

    always_comb
    begin
        if (a == b)
        begin
            cmp_word = rbfalu_pkg::CMP_EQ_WORD;
        end
        else
        begin
            cmp_word = rbfalu_pkg::CMP_NE_BIT
                     | ((a > b) ? rbfalu_pkg::CMP_HI_BITS : rbfalu_pkg::CMP_LS_BITS)
                     | (($signed(a) > $signed(b)) ? rbfalu_pkg::CMP_GT_BITS
                                                  : rbfalu_pkg::CMP_LE_BITS);
        end
    end

    assign neg     = a[rbfalu_pkg::DataW-1];
    assign is_zero = (a == '0);
    assign is_min  = (a == rbfalu_pkg::SIGN_WORD);
    assign taken   = (req.cond_mask[0] && !neg && !is_zero)
                   || (req.cond_mask[1] && is_zero)
                   || (req.cond_mask[2] && neg && !is_min)
                   || (req.cond_mask[3] && is_min);

    always_comb
    begin
        rsp.result       = '0;
        rsp.branch_taken = 1'b0;
        rsp.carry_flag   = carry;
        case (req.req_type)
            rbfalu_pkg::OP_ADD, rbfalu_pkg::OP_SUB:
            begin
                rsp.result = sum[rbfalu_pkg::DataW-1:0];
                if (req.carry_mode[1])
                begin
                    rsp.carry_flag = sum[rbfalu_pkg::DataW];
                end
            end
            rbfalu_pkg::OP_AND:  rsp.result = a & b;
            rbfalu_pkg::OP_ANDC: rsp.result = a & ~b;
            rbfalu_pkg::OP_OR:   rsp.result = a | b;
            rbfalu_pkg::OP_ORC:  rsp.result = a | ~b;
            rbfalu_pkg::OP_XOR:  rsp.result = a ^ b;
            rbfalu_pkg::OP_XORC: rsp.result = a ^ ~b;
            rbfalu_pkg::OP_CMP:  rsp.result = cmp_word;
            rbfalu_pkg::OP_ROT:  rsp.result = rot_wide[rbfalu_pkg::DataW-1:0];
            rbfalu_pkg::OP_MAK:  rsp.result = (a & wm) << off;
            rbfalu_pkg::OP_SET:  rsp.result = a | (wm << off);
            rbfalu_pkg::OP_CLR:  rsp.result = a & ~(wm << off);
            rbfalu_pkg::OP_EXT:  rsp.result = ext_val;
            rbfalu_pkg::OP_EXTU: rsp.result = (a >> off) & wm;
            rbfalu_pkg::OP_COND: rsp.branch_taken = taken;
            default:             rsp.result = '0;
        endcase
    end

endmodule

/* sv/risc_integer_alu_with_bitfield_core.sv */
// pipeline: an accepted word is held in req_reg, then moves into rsp_reg, which drives rsp
// throughput: one word per cycle unless rsp_stall holds the output; the carry flag feeds
// back from the output of the execute logic into its input through carry_reg
// reset: rst_n asynchronous active low clears both valid flags and the carry flag
// top level: input register, rbfalu_exec, output register; depends on rbfalu_pkg
module risc_integer_alu_with_bitfield_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  rbfalu_pkg::req_t req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rbfalu_pkg::rsp_t rsp
);

    rbfalu_pkg::req_t req_reg;
    logic             req_valid_reg;
    logic             req_valid_next;
    rbfalu_pkg::rsp_t rsp_reg;
    rbfalu_pkg::rsp_t rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             carry_reg;
    logic             out_ready;
    logic             advance;
    logic             accept;

    rbfalu_exec u_exec (
        .req   (req_reg),
        .carry (carry_reg),
        .rsp   (rsp_next)
    );

    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign advance   = req_valid_reg && out_ready;
    assign req_stall = req_valid_reg && !out_ready;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
    end

    assign rsp_valid_next = out_ready ? advance : rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            carry_reg     <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                carry_reg <= rsp_next.carry_flag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    // carry only moves when a word leaves the execute stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(carry_reg))
        else $error("carry flag changed without a word moving");

    // the carry reported with a word is the flag left behind by it
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (rsp_reg.carry_flag == carry_reg))
        else $error("reported carry differs from stored carry");

    // a word in the execute stage always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("word lost between stages");

    // upstream stall only when the execute stage is full and blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (req_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("stall raised without a blocked word");
`endif

endmodule

/* dv/risc_integer_alu_with_bitfield_core_tb.sv */
// self-checking testbench for the integer execute unit with bit-field ops
// drives risc_integer_alu_with_bitfield_core through a directed table and random words
// depends on rbfalu_pkg for the request and response word types
module risc_integer_alu_with_bitfield_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RAND_PER_PHASE = 425;

    typedef struct {
        rbfalu_pkg::req_t wd;
        bit               known;
        rbfalu_pkg::rsp_t want;
    } vector_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    rbfalu_pkg::req_t req;
    logic             rsp_valid;
    logic             rsp_stall;
    rbfalu_pkg::rsp_t rsp;

    rbfalu_pkg::rsp_t rsp_due[$];
    vector_t          dir_vec[$];
    logic             model_carry;
    int unsigned      idle_pct;
    int unsigned      stall_pct;
    int unsigned      errors;
    int unsigned      cycle_count;

    risc_integer_alu_with_bitfield_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // expected response for one word; tracks the carry flag like the block does
    function automatic rbfalu_pkg::rsp_t compute_rsp(rbfalu_pkg::req_t wd);
        logic [4:0]       wid;
        logic [4:0]       off;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      wm;
        logic [31:0]      sh;
        logic [31:0]      fld;
        logic [63:0]      dbl;
        logic [32:0]      sum;
        logic             cin;
        rbfalu_pkg::rsp_t r;
        a = wd.operand_a;
        b = wd.operand_b;
        wid = wd.imm_form ? wd.field_width : b[9:5];
        off = wd.imm_form ? wd.field_offset : b[4:0];
        wm = (wid == 5'd0) ? 32'hffff_ffff : (32'd1 << wid) - 32'd1;
        r = '0;
        case (wd.req_type)
            rbfalu_pkg::OP_ADD, rbfalu_pkg::OP_SUB:
            begin
                if (wd.req_type == rbfalu_pkg::OP_SUB)
                    b = ~b;
                cin = wd.carry_mode[0] ? model_carry : (wd.req_type == rbfalu_pkg::OP_SUB);
                sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
                r.result = sum[31:0];
                if (wd.carry_mode[1])
                    model_carry = sum[32];
            end
            rbfalu_pkg::OP_AND:  r.result = a & b;
            rbfalu_pkg::OP_ANDC: r.result = a & ~b;
            rbfalu_pkg::OP_OR:   r.result = a | b;
            rbfalu_pkg::OP_ORC:  r.result = a | ~b;
            rbfalu_pkg::OP_XOR:  r.result = a ^ b;
            rbfalu_pkg::OP_XORC: r.result = a ^ ~b;
            rbfalu_pkg::OP_CMP:
            begin
                if (a == b)
                    r.result = rbfalu_pkg::CMP_EQ_WORD;
                else
                    r.result = rbfalu_pkg::CMP_NE_BIT
                             | ((a > b) ? rbfalu_pkg::CMP_HI_BITS : rbfalu_pkg::CMP_LS_BITS)
                             | (($signed(a) > $signed(b)) ? rbfalu_pkg::CMP_GT_BITS
                                                          : rbfalu_pkg::CMP_LE_BITS);
            end
            rbfalu_pkg::OP_ROT:
            begin
                dbl = {a, a} >> off;
                r.result = dbl[31:0];
            end
            rbfalu_pkg::OP_MAK:  r.result = (a & wm) << off;
            rbfalu_pkg::OP_SET:  r.result = a | (wm << off);
            rbfalu_pkg::OP_CLR:  r.result = a & ~(wm << off);
            rbfalu_pkg::OP_EXT:
            begin
                sh = $signed(a) >>> off;
                if (wid == 5'd0)
                    r.result = sh;
                else
                begin
                    fld = sh & wm;
                    if (fld[wid - 5'd1])
                        fld = fld | ~wm;
                    r.result = fld;
                end
            end
            rbfalu_pkg::OP_EXTU: r.result = (a >> off) & wm;
            default:
            begin
                r.branch_taken = (wd.cond_mask[0] && !a[31] && a != 32'd0)
                               || (wd.cond_mask[1] && a == 32'd0)
                               || (wd.cond_mask[2] && a[31] && a != rbfalu_pkg::SIGN_WORD)
                               || (wd.cond_mask[3] && a == rbfalu_pkg::SIGN_WORD);
            end
        endcase
        r.carry_flag = model_carry;
        return r;
    endfunction

    function automatic rbfalu_pkg::req_t pack_req(rbfalu_pkg::op_t op, logic [31:0] a,
                                                  logic [31:0] b, logic [4:0] fw,
                                                  logic [4:0] fo, logic imm,
                                                  logic [1:0] cm, logic [3:0] mask);
        return rbfalu_pkg::req_t'{op, a, b, fw, fo, imm, cm, mask};
    endfunction

    function automatic void plan_word(rbfalu_pkg::req_t wd, bit known = 1'b0,
                                      rbfalu_pkg::rsp_t want = '0);
        vector_t v;
        v.wd = wd;
        v.known = known;
        v.want = want;
        dir_vec.push_back(v);
    endfunction

    // operands lean toward the corner values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return rbfalu_pkg::SIGN_WORD;
            3: return 32'h7fff_ffff;
            4: return 32'($urandom_range(64));
            5: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic rbfalu_pkg::req_t random_word();
        rbfalu_pkg::req_t wd;
        wd.req_type = rbfalu_pkg::op_t'($urandom_range(15));
        wd.operand_a = pick_operand();
        wd.operand_b = ($urandom_range(7) == 0) ? wd.operand_a : pick_operand();
        wd.field_width = 5'($urandom_range(31));
        wd.field_offset = 5'($urandom_range(31));
        wd.imm_form = 1'($urandom_range(1));
        wd.carry_mode = 2'($urandom_range(3));
        wd.cond_mask = 4'($urandom_range(15));
        return wd;
    endfunction

    task automatic send_word(input rbfalu_pkg::req_t wd, input bit known,
                             input rbfalu_pkg::rsp_t want);
        rbfalu_pkg::rsp_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= wd;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = compute_rsp(wd);
        rsp_due.push_back(known ? want : pred);
    endtask

    // hold off until every outstanding response is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (rsp_due.size() != 0)
            @(posedge clk);
    endtask

    // response side: random stall and in-order compare
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due.size() == 0)
            begin
                $error("unexpected response word: result %h", rsp.result);
                errors++;
            end
            else
            begin
                rbfalu_pkg::rsp_t want;
                want = rsp_due.pop_front();
                if (rsp.result !== want.result)
                begin
                    $error("result: expected %h, actual %h", want.result, rsp.result);
                    errors++;
                end
                if (rsp.branch_taken !== want.branch_taken)
                begin
                    $error("branch_taken: expected %b, actual %b",
                           want.branch_taken, rsp.branch_taken);
                    errors++;
                end
                if (rsp.carry_flag !== want.carry_flag)
                begin
                    $error("carry_flag: expected %b, actual %b",
                           want.carry_flag, rsp.carry_flag);
                    errors++;
                end
            end
        end
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        rsp_stall <= 1'b0;
        model_carry = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        cycle_count = 0;

        // carry starts clear, then is set, cleared and set again by the rows below
        plan_word(pack_req(rbfalu_pkg::OP_ADD, 32'h0, 32'h0,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h0, 1'b0, 1'b0});
        plan_word(pack_req(rbfalu_pkg::OP_ADD, 32'hffff_ffff, 32'h1,
                           5'd0, 5'd0, 1'b1, 2'd2, 4'h0), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h0, 1'b0, 1'b1});
        plan_word(pack_req(rbfalu_pkg::OP_ADD, 32'h7fff_ffff, 32'h1,
                           5'd0, 5'd0, 1'b1, 2'd3, 4'h0), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h8000_0001, 1'b0, 1'b0});
        plan_word(pack_req(rbfalu_pkg::OP_SUB, 32'h0, 32'h1,
                           5'd0, 5'd0, 1'b1, 2'd2, 4'h0), 1'b1,
                  rbfalu_pkg::rsp_t'{32'hffff_ffff, 1'b0, 1'b0});
        plan_word(pack_req(rbfalu_pkg::OP_SUB, 32'h5, 32'h5,
                           5'd0, 5'd0, 1'b1, 2'd2, 4'h0), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h0, 1'b0, 1'b1});
        plan_word(pack_req(rbfalu_pkg::OP_SUB, 32'ha, 32'h3,
                           5'd0, 5'd0, 1'b1, 2'd1, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_AND, 32'hffff_ffff, 32'h0f0f_0f0f,
                           5'd31, 5'd31, 1'b0, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_ANDC, 32'hffff_ffff, 32'h0f0f_0f0f,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_OR, 32'h0, 32'h8000_0001,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_ORC, 32'h0, 32'hffff_ffff,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_XOR, 32'haaaa_5555, 32'hffff_ffff,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_XORC, 32'haaaa_5555, 32'h0,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_CMP, rbfalu_pkg::SIGN_WORD, rbfalu_pkg::SIGN_WORD,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0), 1'b1,
                  rbfalu_pkg::rsp_t'{rbfalu_pkg::CMP_EQ_WORD, 1'b0, 1'b1});
        plan_word(pack_req(rbfalu_pkg::OP_CMP, 32'h0, rbfalu_pkg::SIGN_WORD,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_ROT, 32'h1234_5678, 32'h0,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h1234_5678, 1'b0, 1'b1});
        // register form: offset from operand_b bits 4:0
        plan_word(pack_req(rbfalu_pkg::OP_ROT, 32'h8000_0001, 32'h0000_001f,
                           5'd0, 5'd0, 1'b0, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_MAK, 32'hdead_beef, 32'h0,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_MAK, 32'h0000_00ff, 32'h0,
                           5'd8, 5'd28, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_SET, 32'h0, 32'h0,
                           5'd0, 5'd4, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_CLR, 32'hffff_ffff, 32'h0,
                           5'd4, 5'd30, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_EXT, 32'h0000_0f80, 32'h0,
                           5'd8, 5'd4, 1'b1, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_EXT, rbfalu_pkg::SIGN_WORD, 32'h0,
                           5'd0, 5'd31, 1'b1, 2'd0, 4'h0), 1'b1,
                  rbfalu_pkg::rsp_t'{32'hffff_ffff, 1'b0, 1'b1});
        plan_word(pack_req(rbfalu_pkg::OP_EXTU, 32'hffff_ffff, 32'h0000_03e0,
                           5'd0, 5'd0, 1'b0, 2'd0, 4'h0));
        plan_word(pack_req(rbfalu_pkg::OP_COND, 32'h1, 32'h0,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h1), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h0, 1'b1, 1'b1});
        plan_word(pack_req(rbfalu_pkg::OP_COND, rbfalu_pkg::SIGN_WORD, 32'h0,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h8), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h0, 1'b1, 1'b1});
        plan_word(pack_req(rbfalu_pkg::OP_COND, rbfalu_pkg::SIGN_WORD, 32'h0,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h4), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h0, 1'b0, 1'b1});
        plan_word(pack_req(rbfalu_pkg::OP_COND, 32'h0, 32'h0,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h2), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h0, 1'b1, 1'b1});
        plan_word(pack_req(rbfalu_pkg::OP_COND, 32'h0, 32'h0,
                           5'd0, 5'd0, 1'b1, 2'd0, 4'h0), 1'b1,
                  rbfalu_pkg::rsp_t'{32'h0, 1'b0, 1'b1});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_vec[i])
            send_word(dir_vec[i].wd, dir_vec[i].known, dir_vec[i].want);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            repeat (RAND_PER_PHASE)
                send_word(random_word(), 1'b0, rbfalu_pkg::rsp_t'('0));
            drain();
        end

        // keep clocking in case a stray word is still in flight
        stall_pct = 0;
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
